// ----- rtl/smlt_pkg.sv -----
// Shared types, register indexes and byte helpers for the substring match line tracker.
// Used by smlt_cfg, smlt_cell and substring_match_line_tracker_top; depends on nothing.
package smlt_pkg;

    // Width of the reported position and line fields.
    localparam int OUT_W = 32;
    localparam logic [OUT_W-1:0] OUT_MAX = 32'hFFFF_FFFF;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_WORDS   = 4;
    localparam int CFG_LEN_W   = 6;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_SENSITIVE = 3'd5;

    // Characters of interest.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [OUT_W-1:0] match_position;
        logic [OUT_W-1:0] match_line;
    } t_out_item;

    // Per-cell settings derived from the pattern registers.
    typedef struct packed {
        logic [7:0] pat;    // pattern byte this cell compares against (folded if needed)
        logic       care;   // cell lies inside the active pattern length
        logic       start;  // cell holds the candidate start byte
    } t_cell_cfg;

    // Per-cell compare results.
    typedef struct packed {
        logic hit;
        logic newline;
    } t_cell_res;

    // Fold ASCII upper-case letters to lower case.
    function automatic logic [7:0] f_fold_byte(input logic [7:0] b);
        if (b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

// ----- rtl/substring_match_line_tracker_top.sv -----
// Streaming substring search with line tracking over a chain of window cells.
// A match is shown on the output in the cycle after its last byte is accepted.
// Throughput: one text byte per cycle; all cells compare in the accept cycle.
// A result held in the output register stalls the input until it is taken, so with the
// result channel ready bytes follow back to back.
// Reset is synchronous and active low, and takes effect with no clearing pass.
// Depends on smlt_pkg, smlt_cfg and smlt_cell.
module substring_match_line_tracker_top #(
    parameter int MAX_PATTERN = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  smlt_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output smlt_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smlt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [smlt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import smlt_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int SKIP_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int EXT_W  = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [LEN_W-1:0]             w_len;
    logic                         w_fold;
    t_cell_cfg [MAX_PATTERN-1:0]  w_cell_cfg;
    t_cell_res [MAX_PATTERN-1:0]  w_cell_res;
    logic [7:0]                   w_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]       w_hits;
    logic [MAX_PATTERN-1:0]       w_nls;

    logic                         w_in_fire;
    logic                         w_due;
    logic                         w_hit;
    logic [LEN_W-1:0]             w_fill_inc;
    logic [COUNT_BITS-1:0]        w_line_upd;
    logic [COUNT_BITS-1:0]        w_pos;

    logic [LEN_W-1:0]             r_fill, n_fill;
    logic [COUNT_BITS-1:0]        r_byte_count, n_byte_count;
    logic [COUNT_BITS-1:0]        r_line, n_line;
    logic [SKIP_W-1:0]            r_skip, n_skip;
    logic                         r_out_valid, n_out_valid;
    t_out_item                    r_out_data, n_out_data;

    // Saturate a count to the output field width.
    function automatic logic [OUT_W-1:0] f_clamp(input logic [COUNT_BITS-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return ext[OUT_W-1:0];
    endfunction

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    smlt_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_len       (w_len),
        .o_fold      (w_fold),
        .o_cell_cfg  (w_cell_cfg)
    );

    // Input handshake: a new byte enters unless a result is stuck in the output register.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Window chain, newest byte in cell 0.
    assign w_chain[0] = i_in_data.text_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        smlt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_in_fire),
            .i_byte  (w_chain[k]),
            .i_fold  (w_fold),
            .i_cfg   (w_cell_cfg[k]),
            .o_byte  (w_chain[k+1]),
            .o_res   (w_cell_res[k])
        );
        assign w_hits[k] = w_cell_res[k].hit;
        assign w_nls[k]  = w_cell_res[k].newline;
    end

    // Start-position bookkeeping, line counting and result capture.
    always_comb begin
        w_fill_inc = (r_fill == LEN_W'(MAX_PATTERN)) ? r_fill : r_fill + LEN_W'(1);
        w_due      = (w_len != '0) && (w_fill_inc >= w_len);
        w_line_upd = (|w_nls && r_line != COUNT_MAX) ? r_line + COUNT_BITS'(1) : r_line;
        w_hit      = w_in_fire && w_due && (r_skip == '0) && (&w_hits);
        w_pos      = (r_byte_count == COUNT_MAX)
                   ? COUNT_MAX
                   : r_byte_count - (COUNT_BITS'(w_len) - COUNT_BITS'(1));

        n_fill       = r_fill;
        n_byte_count = r_byte_count;
        n_line       = r_line;
        n_skip       = r_skip;
        n_out_data   = r_out_data;
        n_out_valid  = (r_out_valid && !i_out_ready) || w_hit;

        if (w_in_fire) begin
            n_fill       = w_fill_inc;
            n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count
                                                       : r_byte_count + COUNT_BITS'(1);
            if (w_due) begin
                if (r_skip != '0) begin
                    n_skip = r_skip - SKIP_W'(1);
                end else begin
                    n_line = w_line_upd;
                end
            end
            if (w_hit) begin
                n_skip                    = SKIP_W'(w_len - LEN_W'(1));
                n_out_data.match_position = f_clamp(w_pos);
                n_out_data.match_line     = f_clamp(w_line_upd);
            end
            if (i_in_data.last) begin
                n_fill       = '0;
                n_byte_count = '0;
                n_line       = COUNT_BITS'(1);
                n_skip       = '0;
            end
        end
    end

    // Tracking state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_byte_count <= '0;
            r_line       <= COUNT_BITS'(1);
            r_skip       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_byte_count <= n_byte_count;
            r_line       <= n_line;
            r_skip       <= n_skip;
            r_out_valid  <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // The last byte of a text leaves the tracking state as after reset.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_data.last) |=>
            (r_fill == '0 && r_skip == '0 && r_byte_count == '0 && r_line == COUNT_BITS'(1)))
        else $error("state not cleared after the last byte of a text");

    // A new result only ever follows an accepted byte.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_fire))
        else $error("result appeared without an accepted transaction");

    // After a match inside a text, the following overlapping starts are skipped.
    a_skip_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit && !i_in_data.last) |=> (r_skip == $past(SKIP_W'(w_len - LEN_W'(1)))))
        else $error("skip count not loaded after a match");

    // The line number never drops below one.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count reached zero");
`endif

endmodule

// ----- rtl/smlt_cfg.sv -----
// Configuration registers and the per-cell alignment of the pattern to the byte window.
// Depends on smlt_pkg.
module smlt_cfg #(
    parameter int MAX_PATTERN = 32,
    parameter int LEN_W       = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_write,
    input  logic [smlt_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [smlt_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [LEN_W-1:0]                       o_len,
    output logic                                   o_fold,
    output smlt_pkg::t_cell_cfg [MAX_PATTERN-1:0]  o_cell_cfg
);
    import smlt_pkg::*;

    localparam int PAT_BITS = 8 * MAX_PATTERN;

    logic [CFG_DATA_W-1:0]             r_pat_word [PAT_WORDS];
    logic [CFG_DATA_W-1:0]             n_pat_word [PAT_WORDS];
    logic [CFG_LEN_W-1:0]              r_len, n_len;
    logic                              r_case, n_case;
    logic [LEN_W-1:0]                  r_len_c, n_len_c;
    t_cell_cfg [MAX_PATTERN-1:0]       r_cell_cfg, n_cell_cfg;

    logic [PAT_WORDS*CFG_DATA_W-1:0]   w_all_bytes;
    logic [PAT_BITS-1:0]               w_rev;
    logic [PAT_BITS-1:0]               w_aligned;
    logic [LEN_W-1:0]                  w_shift;
    logic [7:0]                        w_byte;

    // Register writes.
    always_comb begin
        n_pat_word = r_pat_word;
        n_len      = r_len;
        n_case     = r_case;
        if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_PATTERN_WORD_0: n_pat_word[0] = i_cfg_data;
                CFG_PATTERN_WORD_1: n_pat_word[1] = i_cfg_data;
                CFG_PATTERN_WORD_2: n_pat_word[2] = i_cfg_data;
                CFG_PATTERN_WORD_3: n_pat_word[3] = i_cfg_data;
                CFG_PATTERN_LENGTH: n_len = i_cfg_data[CFG_LEN_W-1:0];
                CFG_CASE_SENSITIVE: n_case = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the length and line the pattern up with the window, so that cell k
    // compares against pattern byte len-1-k. The pattern is reversed and then
    // shifted down by the unused bytes.
    always_comb begin
        n_len_c = (n_len > CFG_LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                    : n_len[LEN_W-1:0];
        w_all_bytes = {n_pat_word[3], n_pat_word[2], n_pat_word[1], n_pat_word[0]};
        w_byte = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_byte = w_all_bytes[8*j +: 8];
            w_rev[8*(MAX_PATTERN-1-j) +: 8] = n_case ? w_byte : f_fold_byte(w_byte);
        end
        w_shift   = LEN_W'(MAX_PATTERN) - n_len_c;
        w_aligned = w_rev >> {w_shift, 3'b000};
        for (int k = 0; k < MAX_PATTERN; k++) begin
            n_cell_cfg[k].pat   = w_aligned[8*k +: 8];
            n_cell_cfg[k].care  = LEN_W'(k) < n_len_c;
            n_cell_cfg[k].start = LEN_W'(k + 1) == n_len_c;
        end
    end

    // Configuration state and its derived per-cell view.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
            r_len      <= '0;
            r_case     <= 1'b1;
            r_len_c    <= '0;
            r_cell_cfg <= '0;
        end else begin
            r_pat_word <= n_pat_word;
            r_len      <= n_len;
            r_case     <= n_case;
            r_len_c    <= n_len_c;
            r_cell_cfg <= n_cell_cfg;
        end
    end

    assign o_len      = r_len_c;
    assign o_fold     = ~r_case;
    assign o_cell_cfg = r_cell_cfg;

endmodule

// ----- rtl/smlt_cell.sv -----
// One window cell: holds a text byte, passes it on, and compares the incoming byte.
// Depends on smlt_pkg.
module smlt_cell (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic [7:0]           i_byte,
    input  logic                 i_fold,
    input  smlt_pkg::t_cell_cfg  i_cfg,
    output logic [7:0]           o_byte,
    output smlt_pkg::t_cell_res  o_res
);
    import smlt_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] w_text;

    // Compare the byte this cell is about to hold with its pattern byte.
    always_comb begin
        w_text        = i_fold ? f_fold_byte(i_byte) : i_byte;
        o_res.hit     = !i_cfg.care || (w_text == i_cfg.pat);
        o_res.newline = i_cfg.start && (i_byte == NEWLINE_BYTE);
    end

    // Window byte, shifted on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- dv/smlt_match_checker.sv -----
// Match checker for the substring match line tracker: watches the input, result and
// register write channels, predicts every match and compares it with the block's results.
// Depends on smlt_pkg for the transaction types, register indexes and the newline byte.
module smlt_match_checker #(
    parameter int MAX_PATTERN = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  smlt_pkg::t_in_item                i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  smlt_pkg::t_out_item               i_out_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [smlt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [smlt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import smlt_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Shadow copy of the configuration registers.
    logic [CFG_DATA_W-1:0] pattern_words [PAT_WORDS];
    logic [CFG_LEN_W-1:0]  pattern_length;
    logic                  case_sensitive;

    // Shadow copy of the text scan state.
    logic [7:0]            window [MAX_PATTERN];
    int                    window_fill;
    logic [COUNT_BITS-1:0] byte_count;
    logic [COUNT_BITS-1:0] line_count;
    int                    skip_left;

    // Matches predicted but not yet seen on the result channel.
    t_out_item expected_hits [$];
    t_out_item want;
    int        mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // ASCII upper-case letters compare as their lower-case forms.
    function automatic logic [7:0] fold_letter(input logic [7:0] b);
        if (b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

    // Start of a new text: empty window, counters back to their first values.
    task automatic clear_text_state();
        foreach (window[k]) window[k] = 8'h00;
        window_fill = 0;
        byte_count  = '0;
        line_count  = 1;
        skip_left   = 0;
    endtask

    // Advance the scan by one text byte and queue the match it completes, if any.
    task automatic predict_text_byte(input t_in_item item);
        int          len;
        int          j;
        bit          hit;
        logic [7:0]  t;
        logic [7:0]  p;
        logic [63:0] pos;
        t_out_item   res;

        for (j = MAX_PATTERN - 1; j > 0; j--) window[j] = window[j-1];
        window[0] = item.text_byte;
        if (window_fill < MAX_PATTERN) window_fill++;

        // Lengths past the window size behave as the full window.
        len = (pattern_length > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_length);

        if (len > 0 && window_fill >= len) begin
            if (skip_left > 0) begin
                // This start position lies inside the previous match.
                skip_left--;
            end else begin
                if (window[len-1] == NEWLINE_BYTE && line_count != COUNT_MAX) begin
                    line_count++;
                end
                hit = 1'b1;
                for (j = 0; j < len; j++) begin
                    t = window[len-1-j];
                    p = pattern_words[j/8][(j%8)*8 +: 8];
                    if (!case_sensitive) begin
                        t = fold_letter(t);
                        p = fold_letter(p);
                    end
                    if (t != p) hit = 1'b0;
                end
                if (hit) begin
                    // Both reported values saturate at the output field's maximum.
                    pos = (byte_count == COUNT_MAX) ? 64'(COUNT_MAX)
                                                    : 64'(byte_count) - 64'(len - 1);
                    res.match_position = (pos > 64'(OUT_MAX)) ? OUT_MAX : pos[OUT_W-1:0];
                    res.match_line     = (64'(line_count) > 64'(OUT_MAX))
                                       ? OUT_MAX : OUT_W'(line_count);
                    expected_hits.push_back(res);
                    skip_left = len - 1;
                end
            end
        end

        if (byte_count != COUNT_MAX) byte_count++;
        if (item.last) clear_text_state();
    endtask

    // Results are checked before the same cycle's input transaction is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pattern_words[k]) pattern_words[k] = '0;
            pattern_length = '0;
            case_sensitive = 1'b1;
            clear_text_state();
            expected_hits.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual position %0d line %0d",
                             $time, i_out_data.match_position, i_out_data.match_line);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.match_position !== i_out_data.match_position) begin
                        mismatches++;
                        $display("%0t: match_position expected %0d actual %0d",
                                 $time, want.match_position, i_out_data.match_position);
                    end
                    if (want.match_line !== i_out_data.match_line) begin
                        mismatches++;
                        $display("%0t: match_line expected %0d actual %0d",
                                 $time, want.match_line, i_out_data.match_line);
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PATTERN_WORD_0: pattern_words[0] = i_cfg_data;
                    CFG_PATTERN_WORD_1: pattern_words[1] = i_cfg_data;
                    CFG_PATTERN_WORD_2: pattern_words[2] = i_cfg_data;
                    CFG_PATTERN_WORD_3: pattern_words[3] = i_cfg_data;
                    CFG_PATTERN_LENGTH: pattern_length = i_cfg_data[CFG_LEN_W-1:0];
                    CFG_CASE_SENSITIVE: case_sensitive = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) predict_text_byte(i_in_data);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_hits.size();
    end

endmodule

// ----- dv/substring_match_line_tracker_top_tb.sv -----
// Testbench top for the substring match line tracker: drives text bytes, register writes
// and result backpressure, and gives the verdict. Depends on smlt_pkg and smlt_match_checker.
module substring_match_line_tracker_top_tb;
    import smlt_pkg::*;

    localparam int MAX_PATTERN    = 32;
    localparam int CFG_LEN_MAX    = (1 << CFG_LEN_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_BYTES    = 78;
    localparam int HOLD_PHASE     = 5;

    // Receiver backpressure patterns.
    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_data;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    int failures;
    int pending_hits;
    int burst_left    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int idle_cycles   = 0;

    // Pattern currently loaded, kept so that the text can embed copies of it.
    logic [7:0] pat_bytes [MAX_PATTERN];
    int         cur_len = 0;
    bit         cur_cs  = 1'b1;

    substring_match_line_tracker_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    smlt_match_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (failures),
        .o_pending    (pending_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: too many cycles without any transaction on any channel ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: stretches of one backpressure pattern each, plus long hold-offs on request.
    initial begin
        t_rx_mode mode;
        int       stretch_left;
        int       tick;
        mode         = RX_ALWAYS;
        stretch_left = 0;
        tick         = 0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end else begin
                if (stretch_left == 0) begin
                    mode         = t_rx_mode'($urandom_range(0, 3));
                    stretch_left = $urandom_range(8, 64);
                end
                stretch_left--;
                tick++;
                case (mode)
                    RX_ALWAYS: i_out_ready <= 1'b1;
                    RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Filler text: letters of both cases, newlines, pattern bytes and arbitrary bytes.
    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 6))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            3:       return "B";
            4:       return NEWLINE_BYTE;
            5:       return 8'($urandom_range(0, 255));
            default: return pat_bytes[$urandom_range(0, MAX_PATTERN - 1)];
        endcase
    endfunction

    // One input transaction; the sender goes idle for a while between bursts.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        t_in_item item;
        item.text_byte = b;
        item.last      = lst;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // A whole text, with the last flag on its final byte.
    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Waits until every predicted match has come out and the block has gone quiet.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_hits != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Loads the pattern bytes, length and case mode, plus one write to an unused index.
    task automatic configure(input int len, input bit cs);
        logic [CFG_DATA_W-1:0] word;
        wait_idle();
        for (int w = 0; w < PAT_WORDS; w++) begin
            for (int k = 0; k < 8; k++) word[k*8 +: 8] = pat_bytes[w*8 + k];
            write_reg(CFG_INDEX_W'(CFG_PATTERN_WORD_0 + w), word);
        end
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_CASE_SENSITIVE, CFG_DATA_W'(cs));
        write_reg(CFG_INDEX_W'(CFG_CASE_SENSITIVE + 1 + $urandom_range(0, 1)),
                  {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        cur_len = len;
        cur_cs  = cs;
    endtask

    // Pattern from a string; bytes past its end are random so they are known not to matter.
    task automatic set_pattern(input string s);
        foreach (pat_bytes[k]) begin
            pat_bytes[k] = (k < s.len()) ? s[k] : 8'($urandom_range(0, 255));
        end
    endtask

    // Random text in which copies of the pattern, some case flipped or broken, are common.
    task automatic send_text(input int n);
        int         sent;
        int         active;
        int         corrupt;
        logic [7:0] b;
        logic [7:0] lowered;
        sent   = 0;
        active = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
        while (sent < n) begin
            if (active > 0 && $urandom_range(0, 2) == 0) begin
                corrupt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, active - 1) : -1;
                for (int k = 0; k < active; k++) begin
                    b       = pat_bytes[k];
                    lowered = b | CASE_OFFSET;
                    if (!cur_cs && lowered >= (UPPER_A | CASE_OFFSET) &&
                        lowered <= (UPPER_Z | CASE_OFFSET) && $urandom_range(0, 1)) begin
                        b = b ^ CASE_OFFSET;
                    end
                    if (k == corrupt) b = 8'($urandom_range(0, 255));
                    send_byte(b, $urandom_range(0, 49) == 0);
                    sent++;
                end
            end else begin
                send_byte(pick_text_byte(), $urandom_range(0, 49) == 0);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed texts, then random phases with new settings each.
    initial begin
        int len;
        bit cs;
        foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: zero length, so extreme bytes give no hits.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        i_in_valid <= 1'b0;

        // Folded compare, with newlines at examined start positions.
        set_pattern("aB");
        configure(2, 1'b0);
        send_string("\nAbaB\nab");
        i_in_valid <= 1'b0;

        // Exact compare of the same pattern.
        configure(2, 1'b1);
        send_string("abaB");
        i_in_valid <= 1'b0;

        // Text that ends before a whole pattern has arrived.
        set_pattern("xyz");
        configure(3, 1'b1);
        send_string("xy");
        i_in_valid <= 1'b0;

        // Runs of one letter: hits must not overlap.
        set_pattern("aa");
        configure(2, 1'b1);
        send_string("aaaaa");
        i_in_valid <= 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            cs = $urandom_range(0, 1);
            foreach (pat_bytes[k]) pat_bytes[k] = pick_text_byte();
            case (p)
                0: len = MAX_PATTERN;
                1: len = CFG_LEN_MAX;
                2: begin
                    len = 0;
                    foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
                end
                3: begin
                    len = $urandom_range(1, 4);
                    foreach (pat_bytes[k]) pat_bytes[k] = 8'hFF;
                end
                HOLD_PHASE: len = 1;
                default: len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, MAX_PATTERN)
                                                           : $urandom_range(1, 6);
            endcase
            // Texts may run on across phases, so a length change can land mid text.
            configure(len, cs);
            if (p == HOLD_PHASE) hold_requests++;
            send_text(PHASE_BYTES);
            i_in_valid <= 1'b0;
        end

        wait_idle();
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
